// ===== src/largest_ones_square_area_macros.svh =====
`ifndef LARGEST_ONES_SQUARE_AREA_MACROS_SVH
`define LARGEST_ONES_SQUARE_AREA_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LOSA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LOSA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/losa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package losa_pkg;

    localparam int SIDE_W        = 11;
    localparam int AREA_W        = 21;
    localparam int LEN_W         = 11;
    localparam int MAX_WIDTH_DEF = 1024;

    localparam logic [LEN_W-1:0]  ROW_LENGTH_RESET = 11'd1024;
    localparam logic [AREA_W-1:0] AREA_MAX         = {AREA_W{1'b1}};

    typedef struct packed {
        logic cell_bit;
        logic frame_last;
    } cell_t;

    typedef struct packed {
        logic [AREA_W-1:0] best_area;
        logic [SIDE_W-1:0] best_side;
    } result_t;

    // Square of a side, saturated to the area field.
    function automatic logic [AREA_W-1:0] square_sat(input logic [SIDE_W-1:0] side);
        logic [2*SIDE_W-1:0] prod;
        begin
            prod = (2*SIDE_W)'(side) * (2*SIDE_W)'(side);
            if (prod > (2*SIDE_W)'(AREA_MAX))
            begin
                square_sat = AREA_MAX;
            end
            else
            begin
                square_sat = prod[AREA_W-1:0];
            end
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/losa_line_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module losa_line_mem #(
    parameter int Depth = losa_pkg::MAX_WIDTH_DEF,
    parameter int DataW = losa_pkg::SIDE_W,
    parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             rd_en,
    input  wire logic [AddrW-1:0] rd_addr,
    output logic      [DataW-1:0] rd_data,
    input  wire logic             wr_en,
    input  wire logic [AddrW-1:0] wr_addr,
    input  wire logic [DataW-1:0] wr_data,
    output logic                  busy
);

    logic [DataW-1:0] mem [Depth];
    logic [DataW-1:0] rd_data_reg;
    logic             busy_reg;
    logic             busy_next;
    logic [AddrW-1:0] clr_addr_reg;
    logic [AddrW-1:0] clr_addr_next;
    logic             mem_we;
    logic [AddrW-1:0] mem_addr;
    logic [DataW-1:0] mem_data;

    // After reset every entry is swept to zero, one per cycle.
    always_comb
    begin
        busy_next     = busy_reg;
        clr_addr_next = clr_addr_reg;
        if (busy_reg)
        begin
            if (clr_addr_reg == AddrW'(Depth - 1))
            begin
                busy_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            busy_reg     <= busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    assign mem_we   = busy_reg || wr_en;
    assign mem_addr = busy_reg ? clr_addr_reg : wr_addr;
    assign mem_data = busy_reg ? '0 : wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

`include "largest_ones_square_area_macros.svh"

    `LOSA_ASSERT_IMP(a_clear_covers_all, $fell(busy_reg), $past(clr_addr_reg) == AddrW'(Depth - 1), "line store clear ended early")

endmodule

`default_nettype wire

// ===== src/losa_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none

module losa_scan #(
    parameter int MaxWidth = losa_pkg::MAX_WIDTH_DEF,
    parameter int ColW     = (MaxWidth > 1) ? $clog2(MaxWidth) : 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [losa_pkg::LEN_W-1:0]    row_length,
    input  wire logic                          cell_valid,
    output logic                               cell_stall,
    input  wire losa_pkg::cell_t               cell_data,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output losa_pkg::result_t                  result,
    output logic                               mem_rd_en,
    output logic [ColW-1:0]                    mem_rd_addr,
    input  wire logic [losa_pkg::SIDE_W-1:0]   mem_rd_data,
    output logic                               mem_wr_en,
    output logic [ColW-1:0]                    mem_wr_addr,
    output logic [losa_pkg::SIDE_W-1:0]        mem_wr_data,
    input  wire logic                          clear_busy
);

    localparam int SideW = losa_pkg::SIDE_W;
    localparam int ExtW  = (ColW + 1 > losa_pkg::LEN_W) ? ColW + 1 : losa_pkg::LEN_W;

    logic                 accept;
    logic                 retire;
    logic [ExtW-1:0]      len_ext;
    logic [ExtW-1:0]      len_eff;
    logic                 row_wrap;

    logic [ColW-1:0]      next_col_reg;
    logic [ColW-1:0]      next_col_next;
    logic                 next_first_reg;
    logic                 next_first_next;

    logic                 a_valid_reg;
    logic                 a_valid_next;
    losa_pkg::cell_t      a_item_reg;
    logic [ColW-1:0]      col_reg;
    logic                 first_reg;
    logic                 fwd_hit_reg;
    logic [SideW-1:0]     fwd_data_reg;

    logic [SideW-1:0]     left_reg;
    logic [SideW-1:0]     diag_reg;
    logic [SideW-1:0]     max_reg;
    logic [SideW-1:0]     max_next;

    logic [SideW-1:0]     up;
    logic [SideW-1:0]     diag;
    logic [SideW-1:0]     left;
    logic [SideW-1:0]     min_ul;
    logic [SideW-1:0]     min_all;
    logic [SideW-1:0]     side;
    logic [SideW-1:0]     max_new;

    logic                 result_valid_reg;
    logic                 result_valid_next;
    losa_pkg::result_t    result_reg;

    // Row length of zero acts as one; lengths beyond the line store are clamped.
    always_comb
    begin
        len_ext = ExtW'(row_length);
        if (len_ext == '0)
        begin
            len_eff = ExtW'(1);
        end
        else if (len_ext > ExtW'(MaxWidth))
        begin
            len_eff = ExtW'(MaxWidth);
        end
        else
        begin
            len_eff = len_ext;
        end
    end

    assign row_wrap = (ExtW'(next_col_reg) + ExtW'(1)) >= len_eff;

    assign retire     = a_valid_reg &&
                        !(a_item_reg.frame_last && result_valid_reg && result_stall);
    assign cell_stall = clear_busy || (a_valid_reg && !retire);
    assign accept     = cell_valid && !cell_stall;

    always_comb
    begin
        next_col_next   = next_col_reg;
        next_first_next = next_first_reg;
        if (accept)
        begin
            if (cell_data.frame_last)
            begin
                next_col_next   = '0;
                next_first_next = 1'b1;
            end
            else if (row_wrap)
            begin
                next_col_next   = '0;
                next_first_next = 1'b0;
            end
            else
            begin
                next_col_next = next_col_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        if (accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (retire)
        begin
            a_valid_next = 1'b0;
        end
        else
        begin
            a_valid_next = a_valid_reg;
        end
    end

    // The line store read is issued as the item enters, so its data lines up with it.
    assign mem_rd_en   = accept;
    assign mem_rd_addr = next_col_reg;

    // A write from the retiring item to the column just read is forwarded.
    always_comb
    begin
        up   = '0;
        diag = '0;
        left = '0;
        if (!first_reg)
        begin
            up = fwd_hit_reg ? fwd_data_reg : mem_rd_data;
        end
        if (!first_reg && (col_reg != '0))
        begin
            diag = diag_reg;
        end
        if (col_reg != '0)
        begin
            left = left_reg;
        end
        min_ul  = (left < up) ? left : up;
        min_all = (min_ul < diag) ? min_ul : diag;
        side    = a_item_reg.cell_bit ? min_all + 1'b1 : '0;
        max_new = (side > max_reg) ? side : max_reg;
    end

    assign mem_wr_en   = retire;
    assign mem_wr_addr = col_reg;
    assign mem_wr_data = side;

    always_comb
    begin
        max_next = max_reg;
        if (retire)
        begin
            max_next = a_item_reg.frame_last ? '0 : max_new;
        end
    end

    always_comb
    begin
        if (retire && a_item_reg.frame_last)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_col_reg     <= '0;
            next_first_reg   <= 1'b1;
            a_valid_reg      <= 1'b0;
            col_reg          <= '0;
            first_reg        <= 1'b1;
            fwd_hit_reg      <= 1'b0;
            left_reg         <= '0;
            diag_reg         <= '0;
            max_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            next_col_reg     <= next_col_next;
            next_first_reg   <= next_first_next;
            a_valid_reg      <= a_valid_next;
            max_reg          <= max_next;
            result_valid_reg <= result_valid_next;
            if (accept)
            begin
                col_reg     <= next_col_reg;
                first_reg   <= next_first_reg;
                fwd_hit_reg <= retire && (col_reg == next_col_reg);
            end
            if (retire)
            begin
                left_reg <= side;
                diag_reg <= up;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_item_reg   <= cell_data;
            fwd_data_reg <= side;
        end
        if (retire && a_item_reg.frame_last)
        begin
            result_reg.best_area <= losa_pkg::square_sat(max_new);
            result_reg.best_side <= max_new;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`include "largest_ones_square_area_macros.svh"

    `LOSA_ASSERT_IMP(a_no_accept_in_clear, clear_busy, cell_stall, "item accepted during line store clear")
    `LOSA_ASSERT_NXT(a_last_gives_result, retire && a_item_reg.frame_last, result_valid_reg, "frame end without result")
    `LOSA_ASSERT_NXT(a_frame_restart, accept && cell_data.frame_last, (next_col_reg == '0) && next_first_reg, "frame end did not restart scan")

endmodule

`default_nettype wire

// ===== src/largest_ones_square_area.sv =====
// Streaming largest all-ones square: cells enter one per clock in row-major order while
// cell_stall is low, rows being row_length cells long, and the cell flagged frame_last
// closes the frame. A new cell is accepted every clock unless cell_stall is high; each
// side is computed against the single-row line store. The result (best side and its area)
// is registered once the last cell retires from the item register and holds until taken;
// while it waits, cells of the next frame keep flowing until another frame end reaches the
// block. After reset the line store is swept to zero, and cell_stall stays high until the
// sweep ends; the row_length register can be written at any time, but only while no item
// is in flight does a write take a defined effect.
`timescale 1ns / 1ps
`default_nettype none

module largest_ones_square_area #(
    parameter int MaxWidth = losa_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [losa_pkg::LEN_W-1:0]  cfg_data,
    input  wire logic                        cell_valid,
    output logic                             cell_stall,
    input  wire losa_pkg::cell_t             cell_data,
    output logic                             result_valid,
    input  wire logic                        result_stall,
    output losa_pkg::result_t                result
);

    localparam int ColW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;

    logic [losa_pkg::LEN_W-1:0]  row_length_reg;
    logic [losa_pkg::LEN_W-1:0]  row_length_next;
    logic                        mem_rd_en;
    logic [ColW-1:0]             mem_rd_addr;
    logic [losa_pkg::SIDE_W-1:0] mem_rd_data;
    logic                        mem_wr_en;
    logic [ColW-1:0]             mem_wr_addr;
    logic [losa_pkg::SIDE_W-1:0] mem_wr_data;
    logic                        clear_busy;

    assign cfg_ready       = 1'b1;
    assign row_length_next = (cfg_valid && cfg_ready) ? cfg_data : row_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg <= losa_pkg::ROW_LENGTH_RESET;
        end
        else
        begin
            row_length_reg <= row_length_next;
        end
    end

    losa_line_mem #(
        .Depth (MaxWidth),
        .DataW (losa_pkg::SIDE_W),
        .AddrW (ColW)
    ) u_line_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .busy    (clear_busy)
    );

    losa_scan #(
        .MaxWidth (MaxWidth),
        .ColW     (ColW)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .row_length   (row_length_reg),
        .cell_valid   (cell_valid),
        .cell_stall   (cell_stall),
        .cell_data    (cell_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .mem_rd_en    (mem_rd_en),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_data  (mem_rd_data),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_data  (mem_wr_data),
        .clear_busy   (clear_busy)
    );

endmodule

`default_nettype wire

// ===== tb/tb_largest_ones_square_area.sv =====
`timescale 1ns / 1ps

module tb_largest_ones_square_area;

    localparam int SIDE_W = losa_pkg::SIDE_W;
    localparam int AREA_W = losa_pkg::AREA_W;
    localparam int LEN_W = losa_pkg::LEN_W;
    localparam int LINE_DEPTH = losa_pkg::MAX_WIDTH_DEF;
    localparam int STUCK_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int ITEM_TARGET = 1000;
    localparam int FRAME_TARGET = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [LEN_W-1:0] cfg_data = '0;
    logic cell_valid = 1'b0;
    logic cell_stall;
    losa_pkg::cell_t cell_data = '0;
    logic result_valid;
    logic result_stall = 1'b1;
    losa_pkg::result_t result;

    logic [SIDE_W-1:0] line_sides [0:LINE_DEPTH-1];
    logic [SIDE_W-1:0] left_prev;
    logic [SIDE_W-1:0] diag_prev;
    logic [SIDE_W-1:0] best_so_far;
    logic [LEN_W-1:0] row_len_reg;
    int unsigned col_next;
    bit first_row;

    losa_pkg::result_t due_squares[$];
    int unsigned cells_sent;
    int unsigned frames_sent;
    int unsigned error_count = 0;
    int unsigned stuck_cycles;
    int rx_wait = 0;
    bit calm;
    logic hold_results = 1'b0;

    largest_ones_square_area u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .cell_valid   (cell_valid),
        .cell_stall   (cell_stall),
        .cell_data    (cell_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #10 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
        begin
            return 0;
        end
        if (r < 50)
        begin
            return 0;
        end
        if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic clear_frame();
        left_prev = '0;
        diag_prev = '0;
        col_next = 0;
        first_row = 1'b1;
        best_so_far = '0;
    endtask

    task automatic track_cell(input losa_pkg::cell_t c);
        int unsigned eff;
        int unsigned col;
        logic [SIDE_W-1:0] up;
        logic [SIDE_W-1:0] dg;
        logic [SIDE_W-1:0] lf;
        logic [SIDE_W-1:0] m;
        logic [SIDE_W-1:0] side;
        logic [2*SIDE_W-1:0] sq;
        losa_pkg::result_t r;
        eff = row_len_reg;
        if (eff == 0)
        begin
            eff = 1;
        end
        if (eff > LINE_DEPTH)
        begin
            eff = LINE_DEPTH;
        end
        col = col_next;
        if (col >= LINE_DEPTH)
        begin
            col = 0;
        end
        up = first_row ? '0 : line_sides[col];
        dg = (first_row || col == 0) ? '0 : diag_prev;
        lf = (col == 0) ? '0 : left_prev;
        m = (up < dg) ? up : dg;
        m = (m < lf) ? m : lf;
        side = c.cell_bit ? SIDE_W'(m + 1'b1) : '0;
        diag_prev = up;
        left_prev = side;
        line_sides[col] = side;
        if (side > best_so_far)
        begin
            best_so_far = side;
        end
        if (col + 1 >= eff)
        begin
            col_next = 0;
            first_row = 1'b0;
        end
        else
        begin
            col_next = col + 1;
        end
        if (c.frame_last)
        begin
            sq = (2*SIDE_W)'(best_so_far) * (2*SIDE_W)'(best_so_far);
            r.best_area = (sq > (2*SIDE_W)'(losa_pkg::AREA_MAX)) ? losa_pkg::AREA_MAX
                                                                : sq[AREA_W-1:0];
            r.best_side = best_so_far;
            due_squares = {due_squares, r};
            clear_frame();
        end
    endtask

    task automatic send_cell(input losa_pkg::cell_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cell_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cell_valid <= 1'b1;
        cell_data <= c;
        do
        begin
            @(posedge clk);
        end
        while (cell_stall);
        track_cell(c);
        cells_sent++;
        if (c.frame_last)
        begin
            frames_sent++;
        end
    endtask

    task automatic write_row_length(input int unsigned value);
        cell_valid <= 1'b0;
        wait (due_squares.size() == 0);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value[LEN_W-1:0];
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        row_len_reg = value[LEN_W-1:0];
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pattern(input logic [31:0] bits, input int n);
        losa_pkg::cell_t c;
        for (int i = 0; i < n; i++)
        begin
            c.cell_bit = bits[i];
            c.frame_last = (i == n - 1);
            send_cell(c);
        end
    endtask

    task automatic send_frame(input int unsigned len, input int unsigned rows,
                              input int unsigned tail, input int unsigned pct);
        int unsigned total;
        losa_pkg::cell_t c;
        total = rows * len + tail;
        if (total == 0)
        begin
            total = 1;
        end
        for (int unsigned i = 0; i < total; i++)
        begin
            c.cell_bit = ($urandom_range(0, 99) < pct);
            c.frame_last = (i == total - 1);
            send_cell(c);
        end
    endtask

    task automatic test_reset_length();
        send_pattern(32'b011, 3);
    endtask

    task automatic test_length_limits();
        write_row_length(0);
        send_pattern(32'b111, 3);
        write_row_length(2047);
        send_pattern(32'b11, 2);
    endtask

    task automatic test_small_squares();
        write_row_length(2);
        send_pattern(32'hF, 4);
        send_pattern(32'b00, 2);
        write_row_length(3);
        send_pattern(32'h1FF, 9);
    endtask

    task automatic test_result_backpressure();
        losa_pkg::cell_t c;
        write_row_length(1);
        calm = 1'b1;
        fork
            begin
                hold_results <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results <= 1'b0;
            end
            begin
                for (int i = 0; i < 40; i++)
                begin
                    c.cell_bit = $urandom_range(0, 1);
                    c.frame_last = 1'b1;
                    send_cell(c);
                end
            end
        join
        calm = 1'b0;
    endtask

    task automatic test_full_square();
        write_row_length(16);
        send_frame(16, 16, 0, 100);
    endtask

    task automatic test_random_frames();
        int unsigned pick;
        int unsigned len;
        int unsigned eff;
        int unsigned rows;
        int unsigned tail;
        int unsigned pct;
        while (cells_sent < ITEM_TARGET || frames_sent < FRAME_TARGET)
        begin
            pick = $urandom_range(0, 19);
            case (pick)
                0: len = 0;
                1: len = 1;
                2: len = 1024;
                3: len = 1025;
                4: len = 2047;
                5, 6, 7: len = $urandom_range(13, 40);
                default: len = $urandom_range(2, 12);
            endcase
            eff = (len == 0) ? 1 : ((len > LINE_DEPTH) ? LINE_DEPTH : len);
            write_row_length(len);
            calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 4))
            begin
                if (eff >= 64)
                begin
                    rows = 0;
                    tail = $urandom_range(1, 40);
                end
                else
                begin
                    rows = $urandom_range(1, 48 / eff + 1);
                    tail = ($urandom_range(0, 4) == 0 && eff > 1) ? $urandom_range(1, eff - 1)
                                                                  : 0;
                end
                pct = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
                                                  : $urandom_range(60, 97);
                send_frame(eff, rows, tail, pct);
            end
            calm = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin : result_side
        losa_pkg::result_t want;
        int gap;
        if (rst_n && result_valid && !result_stall)
        begin
            if (due_squares.size() == 0)
            begin
                flag_mismatch("result with no frame pending");
            end
            else
            begin
                want = due_squares.pop_front();
                if (result.best_side !== want.best_side)
                begin
                    flag_mismatch($sformatf("best_side %0d, wanted %0d",
                                            result.best_side, want.best_side));
                end
                if (result.best_area !== want.best_area)
                begin
                    flag_mismatch($sformatf("best_area %0d, wanted %0d",
                                            result.best_area, want.best_area));
                end
            end
        end
        if (hold_results)
        begin
            result_stall <= 1'b1;
        end
        else if (rx_wait > 0)
        begin
            rx_wait <= rx_wait - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            gap = pick_gap();
            rx_wait <= (gap > 0) ? gap - 1 : 0;
            result_stall <= (gap > 0);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stuck_cycles <= 0;
        end
        else if ((cell_valid && !cell_stall) || (result_valid && !result_stall)
                 || (cfg_valid && cfg_ready))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin
        for (int i = 0; i < LINE_DEPTH; i++)
        begin
            line_sides[i] = '0;
        end
        clear_frame();
        row_len_reg = losa_pkg::ROW_LENGTH_RESET;
        cells_sent = 0;
        frames_sent = 0;
        calm = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_length();
        test_length_limits();
        test_small_squares();
        test_result_backpressure();
        test_full_square();
        test_random_frames();

        cell_valid <= 1'b0;
        wait (due_squares.size() == 0);
        repeat (10) @(posedge clk);
        if (error_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/losa_pkg.sv
src/losa_line_mem.sv
src/losa_scan.sv
src/largest_ones_square_area.sv
tb/tb_largest_ones_square_area.sv
